@@ rtl/ufc_pkg.sv @@
// ----------------------------------------------------------------------------
// ufc_pkg: shared types and constants for the union-find connectivity block
// Field widths, item function codes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package ufc_pkg;

  // Fixed field widths of the item and result channels
  localparam int CNT_W = 11;
  localparam int VTX_W = 10;

  // Vertex count register value after reset
  localparam logic [CNT_W-1:0] VCOUNT_RST = 11'd1024;

  // Size of a singleton set
  localparam logic [CNT_W-1:0] SIZE_ONE = 11'd1;

  // Item function codes
  typedef enum logic {
    FUNC_CLEAR   = 1'b0,
    FUNC_CONNECT = 1'b1
  } func_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_INIT,   // sweep the table after reset
    S_CLEAR,  // sweep the table for a clear item
    S_IDLE,   // wait for an item
    S_CHK_A,  // follow parent links from vertex_a
    S_CHK_B,  // follow parent links from vertex_b
    S_GROW,   // write the grown size to the surviving root
    S_LINK,   // link the absorbed root under the survivor
    S_RESP    // load the result register
  } state_t;

endpackage

@@ rtl/union_find_connectivity_top.sv @@
// ----------------------------------------------------------------------------
// union_find_connectivity_top: disjoint-set engine with union by size
// A connect follows the links to the root of a, then to the root of b,
//   one table read per link, and grows and links roots when the sets merge.
// A vertex out of range answers without a table walk. A clear sweeps the
//   whole table and then answers. One item at a time.
// After reset a sweep sets every vertex to a singleton; in_ready stays low
//   meanwhile, configuration writes are taken as ever.
// ----------------------------------------------------------------------------
module union_find_connectivity_top #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_wr_en,
  input  logic [ufc_pkg::CNT_W-1:0] cfg_wr_data,
  // item channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_func,
  input  logic [ufc_pkg::VTX_W-1:0] in_vertex_a,
  input  logic [ufc_pkg::VTX_W-1:0] in_vertex_b,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ufc_pkg::CNT_W-1:0] out_set_count,
  output logic                    out_merged,
  output logic                    out_single_set,
  output logic                    out_range_error
);

  localparam int CW   = ufc_pkg::CNT_W;
  localparam int VW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EW   = 1 + CW + VW;
  localparam int LW   = (VW + 1 > CW) ? VW + 1 : CW;
  localparam int SETS_RST = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;
  localparam logic [LW-1:0] MAX_L  = LW'(MAX_VERTICES);
  localparam logic [VW-1:0] LAST_V = VW'(MAX_VERTICES - 1);

  ufc_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] vcount_r;
  logic [CW-1:0] sets_r,    sets_nxt;
  logic [VW-1:0] idx_r,     idx_nxt;
  logic [VW-1:0] cur_r,     cur_nxt;
  logic [VW-1:0] vb_r,      vb_nxt;
  logic [VW-1:0] root_a_r,  root_a_nxt;
  logic [VW-1:0] root_b_r,  root_b_nxt;
  logic [CW-1:0] size_a_r,  size_a_nxt;
  logic [CW-1:0] size_b_r,  size_b_nxt;
  logic          merged_r,  merged_nxt;
  logic          err_r,     err_nxt;

  logic          out_valid_r,  out_valid_nxt;
  logic [CW-1:0] out_count_r,  out_count_nxt;
  logic          out_merged_r, out_merged_nxt;
  logic          out_single_r, out_single_nxt;
  logic          out_err_r,    out_err_nxt;

  // table port
  logic          wr_en;
  logic [VW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [VW-1:0] rd_addr;
  logic [EW-1:0] rd_data;

  logic          rd_is_root;
  logic [CW-1:0] rd_size;
  logic [VW-1:0] rd_parent;

  logic [LW-1:0] vcount_l;
  logic [CW-1:0] lim;
  logic          out_of_range;
  logic [VW-1:0] addr_a, addr_b;

  // shared compare and add unit
  logic          a_smaller;
  logic [CW-1:0] size_sum;
  logic [VW-1:0] winner, loser;
  logic [CW-1:0] loser_size;

  // Table entry: {is_root, set_size, parent_link}
  assign rd_is_root = rd_data[EW-1];
  assign rd_size    = rd_data[VW +: CW];
  assign rd_parent  = rd_data[VW-1:0];

  // Saturate the vertex count to the table depth
  assign vcount_l     = LW'(vcount_r);
  assign lim          = (vcount_l > MAX_L) ? CW'(MAX_L) : vcount_r;
  assign out_of_range = ({1'b0, in_vertex_a} >= lim) || ({1'b0, in_vertex_b} >= lim);
  assign addr_a       = VW'(in_vertex_a);
  assign addr_b       = VW'(in_vertex_b);

  assign a_smaller  = size_a_r < size_b_r;
  assign size_sum   = size_a_r + size_b_r;
  assign winner     = a_smaller ? root_b_r : root_a_r;
  assign loser      = a_smaller ? root_a_r : root_b_r;
  assign loser_size = a_smaller ? size_a_r : size_b_r;

  ufc_node_mem #(
    .DEPTH (MAX_VERTICES),
    .AW    (VW),
    .DW    (EW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ufc_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= ufc_pkg::VCOUNT_RST;
      sets_r      <= CW'(SETS_RST);
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vcount_r <= cfg_wr_data;
      end
      sets_r      <= sets_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Walk and payload registers
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    vb_r         <= vb_nxt;
    root_a_r     <= root_a_nxt;
    root_b_r     <= root_b_nxt;
    size_a_r     <= size_a_nxt;
    size_b_r     <= size_b_nxt;
    merged_r     <= merged_nxt;
    err_r        <= err_nxt;
    out_count_r  <= out_count_nxt;
    out_merged_r <= out_merged_nxt;
    out_single_r <= out_single_nxt;
    out_err_r    <= out_err_nxt;
  end

  // Next state, table access and result load
  always_comb begin
    state_nxt      = state_r;
    sets_nxt       = sets_r;
    idx_nxt        = idx_r;
    cur_nxt        = cur_r;
    vb_nxt         = vb_r;
    root_a_nxt     = root_a_r;
    root_b_nxt     = root_b_r;
    size_a_nxt     = size_a_r;
    size_b_nxt     = size_b_r;
    merged_nxt     = merged_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_count_nxt  = out_count_r;
    out_merged_nxt = out_merged_r;
    out_single_nxt = out_single_r;
    out_err_nxt    = out_err_r;
    in_ready       = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = {1'b1, ufc_pkg::SIZE_ONE, {VW{1'b0}}};
    rd_addr        = cur_r;

    unique case (state_r)
      ufc_pkg::S_INIT, ufc_pkg::S_CLEAR: begin
        // sweep: make every vertex a singleton root
        wr_en   = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_V) begin
          idx_nxt   = '0;
          state_nxt = (state_r == ufc_pkg::S_INIT) ? ufc_pkg::S_IDLE : ufc_pkg::S_RESP;
        end
      end

      ufc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = addr_a;
        if (in_valid) begin
          merged_nxt = 1'b0;
          err_nxt    = 1'b0;
          if (in_func == ufc_pkg::FUNC_CLEAR) begin
            sets_nxt  = lim;
            idx_nxt   = '0;
            state_nxt = ufc_pkg::S_CLEAR;
          end else if (out_of_range) begin
            err_nxt   = 1'b1;
            state_nxt = ufc_pkg::S_RESP;
          end else begin
            cur_nxt   = addr_a;
            vb_nxt    = addr_b;
            state_nxt = ufc_pkg::S_CHK_A;
          end
        end
      end

      ufc_pkg::S_CHK_A: begin
        // follow one link per cycle until a root is found
        if (rd_is_root) begin
          root_a_nxt = cur_r;
          size_a_nxt = rd_size;
          rd_addr    = vb_r;
          cur_nxt    = vb_r;
          state_nxt  = ufc_pkg::S_CHK_B;
        end else begin
          rd_addr = rd_parent;
          cur_nxt = rd_parent;
        end
      end

      ufc_pkg::S_CHK_B: begin
        if (rd_is_root) begin
          root_b_nxt = cur_r;
          size_b_nxt = rd_size;
          state_nxt  = (cur_r == root_a_r) ? ufc_pkg::S_RESP : ufc_pkg::S_GROW;
        end else begin
          rd_addr = rd_parent;
          cur_nxt = rd_parent;
        end
      end

      ufc_pkg::S_GROW: begin
        // surviving root takes the combined size
        wr_en     = 1'b1;
        wr_addr   = winner;
        wr_data   = {1'b1, size_sum, winner};
        state_nxt = ufc_pkg::S_LINK;
      end

      ufc_pkg::S_LINK: begin
        // absorbed root points at the survivor; drop the set count
        wr_en      = 1'b1;
        wr_addr    = loser;
        wr_data    = {1'b0, loser_size, winner};
        merged_nxt = 1'b1;
        if (sets_r != '0) begin
          sets_nxt = sets_r - 1'b1;
        end
        state_nxt = ufc_pkg::S_RESP;
      end

      ufc_pkg::S_RESP: begin
        // load the result once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_count_nxt  = sets_r;
          out_merged_nxt = merged_r;
          out_single_nxt = (sets_r == CW'(1));
          out_err_nxt    = err_r;
          state_nxt      = ufc_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ufc_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_set_count   = out_count_r;
  assign out_merged      = out_merged_r;
  assign out_single_set  = out_single_r;
  assign out_range_error = out_err_r;

  // A link is only ever written between two distinct roots
  a_link_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ufc_pkg::S_LINK) |-> (root_a_r != root_b_r))
    else $error("link between identical roots");

  // A merged result never carries a range error
  a_merge_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_merged_r) |-> !out_err_r)
    else $error("merged result flagged out of range");

  // single_set follows the reported count
  a_single_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_single_r == (out_count_r == CW'(1))))
    else $error("single_set disagrees with set count");

  // Only a merge changes the set count outside of item acceptance
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ufc_pkg::S_CHK_A || state_r == ufc_pkg::S_CHK_B) |=> $stable(sets_r))
    else $error("set count changed during chain walk");

endmodule

@@ rtl/ufc_node_mem.sv @@
// ----------------------------------------------------------------------------
// ufc_node_mem: vertex table storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ufc_node_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 22
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry every cycle
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ bench/union_find_connectivity_top_test.sv @@
// ----------------------------------------------------------------------------
// union_find_connectivity_top_test: self-checking bench for the DSU engine
// Drives clear and connect transfers through the item channel and keeps a
// union-by-size forest of its own to predict each result. Directed tests
// cover range errors, vertex count extremes, a count raised without a clear
// and deep trees. Random traffic then runs under four idle/stall profiles.
// ----------------------------------------------------------------------------
module union_find_connectivity_top_test;

  localparam int CNT_W       = ufc_pkg::CNT_W;
  localparam int VTX_W       = ufc_pkg::VTX_W;
  localparam int MAXV        = 1024;
  localparam int CYCLE_LIMIT = 800000;
  localparam int DRAIN_WAIT  = 40;

  typedef struct packed {
    logic [CNT_W-1:0] set_count;
    logic             merged;
    logic             single_set;
    logic             range_error;
  } dsu_result_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_ready;
  logic             in_func;
  logic [VTX_W-1:0] in_vertex_a;
  logic [VTX_W-1:0] in_vertex_b;
  logic             out_valid;
  logic             out_ready;
  logic [CNT_W-1:0] out_set_count;
  logic             out_merged;
  logic             out_single_set;
  logic             out_range_error;

  // Forest mirror used for prediction
  logic             forest_is_root [MAXV];
  logic [VTX_W-1:0] forest_parent  [MAXV];
  logic [CNT_W-1:0] forest_size    [MAXV];
  logic [CNT_W-1:0] forest_sets;
  logic [CNT_W-1:0] forest_vcount;

  dsu_result_t pending_results[$];
  int          mismatch_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  union_find_connectivity_top #(
    .MAX_VERTICES(MAXV)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_vertex_a    (in_vertex_a),
    .in_vertex_b    (in_vertex_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_set_count  (out_set_count),
    .out_merged     (out_merged),
    .out_single_set (out_single_set),
    .out_range_error(out_range_error)
  );

  always #5 clk = ~clk;

  // Vertex count in effect, saturated to the table size
  function automatic int active_vertices();
    return (forest_vcount > MAXV) ? MAXV : int'(forest_vcount);
  endfunction

  function automatic void make_singletons();
    for (int i = 0; i < MAXV; i++) begin
      forest_is_root[i] = 1'b1;
      forest_size[i]    = ufc_pkg::SIZE_ONE;
    end
    forest_sets = CNT_W'(active_vertices());
  endfunction

  // Walk parent links up to the root, bounded by the table size
  function automatic logic [VTX_W-1:0] find_root(logic [VTX_W-1:0] v);
    int steps;
    steps = 0;
    while (!forest_is_root[v] && steps < MAXV) begin
      v = forest_parent[v];
      steps++;
    end
    return v;
  endfunction

  // Apply one item to the forest and return the result it produces
  function automatic dsu_result_t apply_union(ufc_pkg::func_t f, logic [VTX_W-1:0] a,
                                              logic [VTX_W-1:0] b);
    dsu_result_t      res;
    logic [VTX_W-1:0] ra;
    logic [VTX_W-1:0] rb;
    int               lim;
    lim = active_vertices();
    res = '0;
    if (f == ufc_pkg::FUNC_CLEAR) begin
      make_singletons();
    end else if (a >= lim || b >= lim) begin
      res.range_error = 1'b1;
    end else begin
      ra = find_root(a);
      rb = find_root(b);
      if (ra != rb) begin
        // smaller set goes under the larger; on a tie b's root goes under a's
        if (forest_size[ra] < forest_size[rb]) begin
          forest_size[rb]    = forest_size[rb] + forest_size[ra];
          forest_is_root[ra] = 1'b0;
          forest_parent[ra]  = rb;
        end else begin
          forest_size[ra]    = forest_size[ra] + forest_size[rb];
          forest_is_root[rb] = 1'b0;
          forest_parent[rb]  = ra;
        end
        if (forest_sets > 0) forest_sets = forest_sets - 1'b1;
        res.merged = 1'b1;
      end
    end
    res.set_count  = forest_sets;
    res.single_set = (forest_sets == 1);
    return res;
  endfunction

  // Send one item; called just after a falling edge, returns after one
  task automatic send_item(ufc_pkg::func_t f, logic [VTX_W-1:0] a, logic [VTX_W-1:0] b);
    dsu_result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= f;
    in_vertex_a <= a;
    in_vertex_b <= b;
    do @(posedge clk); while (!in_ready);
    want = apply_union(f, a, b);
    pending_results.insert(pending_results.size(), want);
    @(negedge clk);
  endtask

  // Hold the sender off until every pending result has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // Write the vertex count while the block is idle
  task automatic set_vertex_count(logic [CNT_W-1:0] value);
    wait_drain();
    cfg_wr_en     <= 1'b1;
    cfg_wr_data   <= value;
    forest_vcount  = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_item(ufc_pkg::FUNC_CONNECT, 10'd0, 10'd1023);
    send_item(ufc_pkg::FUNC_CONNECT, 10'd1023, 10'd0);
    send_item(ufc_pkg::FUNC_CLEAR, 10'd1023, 10'd1023);
  endtask

  task automatic test_range_errors();
    set_vertex_count(11'd5);
    send_item(ufc_pkg::FUNC_CLEAR, 10'd0, 10'd0);
    send_item(ufc_pkg::FUNC_CONNECT, 10'd5, 10'd0);
    send_item(ufc_pkg::FUNC_CONNECT, 10'd0, 10'd5);
    send_item(ufc_pkg::FUNC_CONNECT, 10'd1023, 10'd1023);
    send_item(ufc_pkg::FUNC_CONNECT, 10'd4, 10'd0);
  endtask

  task automatic test_count_extremes();
    // zero vertices: every connect is out of range, a clear gives zero sets
    set_vertex_count(11'd0);
    send_item(ufc_pkg::FUNC_CONNECT, 10'd0, 10'd0);
    send_item(ufc_pkg::FUNC_CLEAR, 10'd0, 10'd0);
    set_vertex_count(11'd1);
    send_item(ufc_pkg::FUNC_CLEAR, 10'd0, 10'd0);
    send_item(ufc_pkg::FUNC_CONNECT, 10'd0, 10'd0);
    // above the table size: saturate to the table size
    set_vertex_count(11'd2047);
    send_item(ufc_pkg::FUNC_CLEAR, 10'd0, 10'd0);
    send_item(ufc_pkg::FUNC_CONNECT, 10'd1023, 10'd0);
  endtask

  task automatic test_count_raised();
    set_vertex_count(11'd2);
    send_item(ufc_pkg::FUNC_CLEAR, 10'd0, 10'd0);
    send_item(ufc_pkg::FUNC_CONNECT, 10'd0, 10'd1);
    // raise without a clear: count reaches zero and stays there
    set_vertex_count(11'd8);
    send_item(ufc_pkg::FUNC_CONNECT, 10'd2, 10'd3);
    send_item(ufc_pkg::FUNC_CONNECT, 10'd4, 10'd5);
  endtask

  task automatic test_deep_trees();
    set_vertex_count(11'd8);
    send_item(ufc_pkg::FUNC_CLEAR, 10'd0, 10'd0);
    // equal-size merges build a tree three links deep
    for (int step = 1; step < 8; step = step * 2)
      for (int v = 0; v < 8; v += 2 * step)
        send_item(ufc_pkg::FUNC_CONNECT, VTX_W'(v), VTX_W'(v + step));
    send_item(ufc_pkg::FUNC_CONNECT, 10'd7, 10'd6);
  endtask

  // One batch of random traffic at a given vertex count
  task automatic run_connect_batch(logic [CNT_W-1:0] vcount, int num_items);
    int               lim;
    int               pick;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    set_vertex_count(vcount);
    lim = active_vertices();
    send_item(ufc_pkg::FUNC_CLEAR, VTX_W'($urandom), VTX_W'($urandom));
    for (int n = 0; n < num_items; n++) begin
      pick = $urandom_range(99);
      a    = VTX_W'($urandom);
      b    = VTX_W'($urandom);
      if (pick < 3) begin
        send_item(ufc_pkg::FUNC_CLEAR, a, b);
      end else if (pick < 13 || lim == 0) begin
        send_item(ufc_pkg::FUNC_CONNECT, a, b);
      end else begin
        a = VTX_W'($urandom_range(0, lim - 1));
        // flip one bit of a now and then: equal-size merges give deep trees
        if (pick < 40) b = a ^ VTX_W'(1 << $urandom_range(0, VTX_W - 1));
        if (pick >= 40 || b >= lim) b = VTX_W'($urandom_range(0, lim - 1));
        send_item(ufc_pkg::FUNC_CONNECT, a, b);
      end
    end
  endtask

  task automatic test_random_traffic();
    int idle_profile [4][2] = '{'{0, 0}, '{76, 0}, '{0, 76}, '{25, 25}};
    for (int p = 0; p < 4; p++) begin
      wait_drain();
      send_idle_pct  = idle_profile[p][0];
      recv_stall_pct = idle_profile[p][1];
      run_connect_batch(11'd2, 25);
      run_connect_batch(11'd8, 50);
      run_connect_batch(11'd64, 90);
      run_connect_batch(11'd1024, 140);
      run_connect_batch(CNT_W'($urandom_range(1, 2047)), 45);
    end
  endtask

  // Receiver stalls, redrawn every cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    dsu_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, set_count %0d", $time, out_set_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_set_count !== want.set_count) begin
          $display("%0t: set_count expected %0d, actual %0d", $time,
                   want.set_count, out_set_count);
          mismatch_count++;
        end
        if (out_merged !== want.merged) begin
          $display("%0t: merged expected %0b, actual %0b", $time,
                   want.merged, out_merged);
          mismatch_count++;
        end
        if (out_single_set !== want.single_set) begin
          $display("%0t: single_set expected %0b, actual %0b", $time,
                   want.single_set, out_single_set);
          mismatch_count++;
        end
        if (out_range_error !== want.range_error) begin
          $display("%0t: range_error expected %0b, actual %0b", $time,
                   want.range_error, out_range_error);
          mismatch_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_func        = ufc_pkg::FUNC_CLEAR;
    in_vertex_a    = '0;
    in_vertex_b    = '0;
    out_ready      = 1'b1;
    mismatch_count = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    forest_vcount  = ufc_pkg::VCOUNT_RST;
    for (int i = 0; i < MAXV; i++) forest_parent[i] = '0;
    make_singletons();

    // Hold reset, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_range_errors();
    test_count_extremes();
    test_count_raised();
    test_deep_trees();
    test_random_traffic();

    wait_drain();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
rtl/ufc_pkg.sv
rtl/ufc_node_mem.sv
rtl/union_find_connectivity_top.sv
bench/union_find_connectivity_top_test.sv
